// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
// Both expect signals named clk and rst_n in scope.
// Do not put a comma at the top level of an argument.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset
`define BDE_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property that must hold in the cycle after the trigger
`define BDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bde_pkg.sv =====
`default_nettype none
package bde_pkg;

  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_MAR    = 4'd3;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [2:0]  WD_LAST      = 3'd6;   // Friday
  localparam logic [2:0]  REST_RESET   = 3'd1;   // Sunday
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [6:0]  LO_MAX       = 7'd99;

  // register index on the config port
  localparam logic REG_REST_WEEKDAY = 1'b0;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_INVALID  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SPLIT,
    S_ZEL,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic split;
    logic zel;
    logic step;
    logic set_inv;
    logic set_ovf;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic valid;
    logic n_zero;
    logic rest_match;
    logic at_end;
  } dp_stat_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
      MONTH_FEB:                                   d = leap ? 5'd29 : 5'd28;
      default:                                     d = 5'd0;
    endcase
    return d;
  endfunction

  // floor(13*(m'+1)/5), m' being the month shifted so that March is 3
  function automatic logic [5:0] zeller_mterm(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one compare and subtract
  function automatic logic [2:0] mod7(input logic [10:0] s);
    logic [4:0] f1;
    logic [3:0] f2;
    f1 = 5'(s[10:9]) + 5'(s[8:6]) + 5'(s[5:3]) + 5'(s[2:0]);
    f2 = 4'(f1[4:3]) + 4'(f1[2:0]);
    return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/business_day_end_date_unit.sv =====
`default_nettype none
// Business day end date unit. Takes a Gregorian start date and a count of
// working days, walks forward one calendar day per clock, and returns the
// end date and its weekday (Zeller numbering, 0 = Saturday .. 6 = Friday).
// Each visited day that is not the rest weekday uses up one count; once the
// count is spent, one more day is skipped if the date lands on the rest
// weekday. Invalid start dates return error 1 with zero date fields, and
// stepping past 31/12/9999 returns error 2 with zero date fields.
// Timing: one item at a time. An item goes through setup (capture, divide by
// 100, split, weekday), then one step per calendar day walked, then a load
// of the output register. The day-step loop of the datapath sets the time
// per item. The result sits in an output register, so a new word is taken
// while the previous result waits on out_tready.
// Config: rest_weekday at byte address 0 (3 bits, resets to 1 = Sunday).
// A value of 7 matches no day, so every day counts and no skip is done.
module business_day_end_date_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // start_day, start_month, start_year, working_days
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // end_day, end_month, end_year, end_weekday, error_code
  // config port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [2:0] rest_r;
  logic       cfg_wr;
  logic [27:0] out_word;

  bde_pkg::dp_cmd_t  cmd;
  bde_pkg::dp_stat_t stat;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= bde_pkg::REST_RESET;
    end else if (cfg_wr && cfg_paddr[2] == bde_pkg::REG_REST_WEEKDAY) begin
      rest_r <= cfg_pwdata[2:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == bde_pkg::REG_REST_WEEKDAY) ? {29'd0, rest_r} : 32'd0;

  // sequencer
  bde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // date arithmetic and output register
  bde_dp u_dp (
    .clk          (clk),
    .in_word      (in_tdata[34:0]),
    .rest_weekday (rest_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_word     (out_word)
  );

  assign out_tdata = {4'd0, out_word};

`include "assert_macros.svh"

  // a taken word leaves the idle state
  `BDE_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "still ready after take")

  // error field carries a defined code
  `BDE_ASSERT(a_err_code, !out_tvalid || out_tdata[27:26] == bde_pkg::ERR_NONE || out_tdata[27:26] == bde_pkg::ERR_INVALID || out_tdata[27:26] == bde_pkg::ERR_OVERFLOW, "bad error code")

  // a good result has a real date and weekday
  `BDE_ASSERT(a_ok_date, !(out_tvalid && out_tdata[27:26] == bde_pkg::ERR_NONE) || (out_tdata[4:0] != 5'd0 && out_tdata[8:5] != 4'd0 && out_tdata[8:5] <= bde_pkg::MONTH_DEC && out_tdata[25:23] <= bde_pkg::WD_LAST), "bad date in result")

  // a failed result carries zero date fields
  `BDE_ASSERT(a_err_zero, !(out_tvalid && out_tdata[27:26] != bde_pkg::ERR_NONE) || out_tdata[25:0] == 26'd0, "date on error")

endmodule
`default_nettype wire

// ===== hdl/bde_ctrl.sv =====
`default_nettype none
module bde_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire bde_pkg::dp_stat_t stat,
  output bde_pkg::dp_cmd_t      cmd
);

  bde_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bde_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bde_pkg::S_IDLE:  if (in_tvalid) state_nxt = bde_pkg::S_DIV;
      bde_pkg::S_DIV:   state_nxt = bde_pkg::S_SPLIT;
      bde_pkg::S_SPLIT: state_nxt = bde_pkg::S_ZEL;
      bde_pkg::S_ZEL:   state_nxt = stat.valid ? bde_pkg::S_WALK : bde_pkg::S_DONE;
      bde_pkg::S_WALK: begin
        // last day of 9999 ends the walk either way; a spent count ends it
        // after the optional rest-day skip taken this cycle
        if (stat.at_end || stat.n_zero) state_nxt = bde_pkg::S_DONE;
      end
      bde_pkg::S_DONE:  if (!out_valid_r || out_tready) state_nxt = bde_pkg::S_IDLE;
      default:          state_nxt = bde_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bde_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      bde_pkg::S_DIV:   cmd.div   = 1'b1;
      bde_pkg::S_SPLIT: cmd.split = 1'b1;
      bde_pkg::S_ZEL: begin
        cmd.zel     = 1'b1;
        cmd.set_inv = !stat.valid;
      end
      bde_pkg::S_WALK: begin
        if (!stat.n_zero || stat.rest_match) begin
          cmd.set_ovf = stat.at_end;
          cmd.step    = !stat.at_end;
        end
      end
      bde_pkg::S_DONE:  cmd.out_load = !out_valid_r || out_tready;
      default: ;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_tready);
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/bde_dp.sv =====
`default_nettype none
module bde_dp (
  input  wire logic             clk,
  input  wire logic [34:0]      in_word,
  input  wire logic [2:0]       rest_weekday,
  input  wire bde_pkg::dp_cmd_t cmd,
  output bde_pkg::dp_stat_t     stat,
  output logic [27:0]           out_word
);

  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  mon_r,   mon_nxt;
  logic [13:0] yr_r,    yr_nxt;
  logic [11:0] n_r,     n_nxt;
  logic [2:0]  wd_r,    wd_nxt;
  logic [6:0]  c100_r,  c100_nxt;   // year mod 100
  logic [1:0]  c4_r,    c4_nxt;     // (year / 100) mod 4
  logic [7:0]  hi_r;
  logic [6:0]  lo_a_r;
  logic [7:0]  hi_a_r;
  logic [5:0]  mterm_r;
  logic        valid_r;
  bde_pkg::err_code_t err_r;
  logic [27:0] out_r;

  // year / 100 by reciprocal
  logic [26:0] prod;
  assign prod = 27'(yr_r) * 27'(bde_pkg::DIV100_MUL);

  // split into century and year of century
  logic [13:0] hundreds;
  logic [6:0]  lo;
  logic        leap_in, early, in_valid;
  assign hundreds = 14'(hi_r) * 14'd100;
  assign lo       = 7'(yr_r - hundreds);
  assign leap_in  = (yr_r[1:0] == 2'd0) && ((lo != 7'd0) || (hi_r[1:0] == 2'd0));
  assign early    = mon_r < bde_pkg::MONTH_MAR;
  assign in_valid = (mon_r != 4'd0) && (mon_r <= bde_pkg::MONTH_DEC) &&
                    (yr_r != 14'd0) && (yr_r <= bde_pkg::YEAR_MAX) &&
                    (day_r != 5'd0) && (day_r <= bde_pkg::days_in(mon_r, leap_in));

  // Zeller sum
  logic [10:0] zsum;
  assign zsum = 11'(day_r) + 11'(mterm_r) + 11'(lo_a_r) + 11'(lo_a_r[6:2])
              + 11'(hi_a_r[7:2]) + 11'(hi_a_r) * 11'd5;

  // day walk
  logic leap, last;
  assign leap = (yr_r[1:0] == 2'd0) && ((c100_r != 7'd0) || (c4_r == 2'd0));
  assign last = day_r == bde_pkg::days_in(mon_r, leap);

  assign stat.valid      = valid_r;
  assign stat.n_zero     = n_r == 12'd0;
  assign stat.rest_match = wd_r == rest_weekday;
  assign stat.at_end     = last && (mon_r == bde_pkg::MONTH_DEC) &&
                           (yr_r >= bde_pkg::YEAR_MAX);

  always_comb begin
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    yr_nxt   = yr_r;
    n_nxt    = n_r;
    wd_nxt   = wd_r;
    c100_nxt = c100_r;
    c4_nxt   = c4_r;
    if (cmd.load) begin
      day_nxt = in_word[4:0];
      mon_nxt = in_word[8:5];
      yr_nxt  = in_word[22:9];
      n_nxt   = in_word[34:23];
    end else if (cmd.split) begin
      c100_nxt = lo;
      c4_nxt   = hi_r[1:0];
    end else if (cmd.zel) begin
      wd_nxt = bde_pkg::mod7(zsum);
    end else if (cmd.step) begin
      if (wd_r != rest_weekday) n_nxt = n_r - 12'd1;
      wd_nxt = (wd_r >= bde_pkg::WD_LAST) ? 3'd0 : wd_r + 3'd1;
      if (!last) begin
        day_nxt = day_r + 5'd1;
      end else begin
        day_nxt = 5'd1;
        if (mon_r == bde_pkg::MONTH_DEC) begin
          mon_nxt  = 4'd1;
          yr_nxt   = yr_r + 14'd1;
          c100_nxt = (c100_r == bde_pkg::LO_MAX) ? 7'd0 : c100_r + 7'd1;
          if (c100_r == bde_pkg::LO_MAX) c4_nxt = c4_r + 2'd1;
        end else begin
          mon_nxt = mon_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    day_r  <= day_nxt;
    mon_r  <= mon_nxt;
    yr_r   <= yr_nxt;
    n_r    <= n_nxt;
    wd_r   <= wd_nxt;
    c100_r <= c100_nxt;
    c4_r   <= c4_nxt;
    if (cmd.div) hi_r <= prod[bde_pkg::DIV100_SHIFT +: 8];
    if (cmd.split) begin
      valid_r <= in_valid;
      mterm_r <= bde_pkg::zeller_mterm(mon_r);
      if (early && lo == 7'd0) begin
        lo_a_r <= bde_pkg::LO_MAX;
        hi_a_r <= hi_r - 8'd1;
      end else begin
        lo_a_r <= early ? lo - 7'd1 : lo;
        hi_a_r <= hi_r;
      end
    end
    if (cmd.load)         err_r <= bde_pkg::ERR_NONE;
    else if (cmd.set_inv) err_r <= bde_pkg::ERR_INVALID;
    else if (cmd.set_ovf) err_r <= bde_pkg::ERR_OVERFLOW;
    if (cmd.out_load) begin
      if (err_r == bde_pkg::ERR_NONE) out_r <= {err_r, wd_r, yr_r, mon_r, day_r};
      else                            out_r <= {err_r, 26'd0};
    end
  end

  assign out_word = out_r;

endmodule
`default_nettype wire

// ===== test/tb_business_day_end_date_unit.sv =====
`timescale 1ns / 1ps
module tb_business_day_end_date_unit;

  // in_tdata:  start_day[4:0], start_month[8:5], start_year[22:9], working_days[34:23]
  // out_tdata: end_day[4:0], end_month[8:5], end_year[22:9], end_weekday[25:23],
  //            error_code[27:26]
  localparam int ITEMS_PER_PHASE = 19;
  localparam int HOLD_CYCLES     = 400;   // long out_tready hold-off, fills the block

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    bde_pkg::err_code_t err;
  } end_date_t;

  // directed row: rest weekday to run under, start date, count, and whether
  // the result is typed in (error rows) rather than taken from the predictor
  typedef struct {
    logic [2:0]  rest;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [11:0] count;
    bit          typed;
    bde_pkg::err_code_t err;
  } start_row_t;

  localparam int NUM_ROWS = 25;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  end_date_t   pending_dates[$];     // expected end dates, oldest first
  logic [2:0]  rest_setting = bde_pkg::REST_RESET;
  int          mismatches = 0;
  bit          calm = 1'b0;          // no idling on either side while set
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  logic [2:0]  phase_rests [5] = '{3'd0, 3'd6, 3'd7, 3'd3, 3'd5};

  start_row_t  start_rows [NUM_ROWS] = '{
    // reset setting (Sunday is the rest day)
    '{3'd1, 5'd1,  4'd1,  14'd1,     12'd0,    1'b0, bde_pkg::ERR_NONE}, // earliest date
    '{3'd1, 5'd31, 4'd12, 14'd9999,  12'd0,    1'b0, bde_pkg::ERR_NONE}, // last date, Friday
    '{3'd1, 5'd31, 4'd12, 14'd9999,  12'd1,    1'b1, bde_pkg::ERR_OVERFLOW}, // walks off the end
    '{3'd1, 5'd30, 4'd12, 14'd9999,  12'd3,    1'b1, bde_pkg::ERR_OVERFLOW},
    '{3'd1, 5'd0,  4'd1,  14'd2000,  12'd5,    1'b1, bde_pkg::ERR_INVALID},  // day 0
    '{3'd1, 5'd31, 4'd4,  14'd2000,  12'd0,    1'b1, bde_pkg::ERR_INVALID},  // 31 April
    '{3'd1, 5'd29, 4'd2,  14'd1900,  12'd0,    1'b1, bde_pkg::ERR_INVALID},  // century, no leap
    '{3'd1, 5'd29, 4'd2,  14'd2000,  12'd1,    1'b0, bde_pkg::ERR_NONE}, // 400-year leap
    '{3'd1, 5'd29, 4'd2,  14'd2024,  12'd3,    1'b0, bde_pkg::ERR_NONE},
    '{3'd1, 5'd1,  4'd0,  14'd2000,  12'd0,    1'b1, bde_pkg::ERR_INVALID},  // month 0
    '{3'd1, 5'd1,  4'd13, 14'd2000,  12'd0,    1'b1, bde_pkg::ERR_INVALID},
    '{3'd1, 5'd1,  4'd15, 14'd2000,  12'd7,    1'b1, bde_pkg::ERR_INVALID},
    '{3'd1, 5'd1,  4'd1,  14'd0,     12'd0,    1'b1, bde_pkg::ERR_INVALID},  // year 0
    '{3'd1, 5'd1,  4'd1,  14'd10000, 12'd0,    1'b1, bde_pkg::ERR_INVALID},
    '{3'd1, 5'd31, 4'd15, 14'd16383, 12'd4095, 1'b1, bde_pkg::ERR_INVALID},  // all ones
    '{3'd1, 5'd28, 4'd2,  14'd2023,  12'd4095, 1'b0, bde_pkg::ERR_NONE}, // longest walk
    '{3'd1, 5'd31, 4'd12, 14'd1999,  12'd1,    1'b0, bde_pkg::ERR_NONE}, // year rollover
    '{3'd1, 5'd2,  4'd1,  14'd2000,  12'd0,    1'b0, bde_pkg::ERR_NONE}, // Sunday: skip
    '{3'd1, 5'd15, 4'd6,  14'd2021,  12'd10,   1'b0, bde_pkg::ERR_NONE},
    '{3'd1, 5'd31, 4'd1,  14'd2023,  12'd20,   1'b0, bde_pkg::ERR_NONE},
    '{3'd1, 5'd30, 4'd11, 14'd8191,  12'd2730, 1'b0, bde_pkg::ERR_NONE},
    '{3'd1, 5'd29, 4'd2,  14'd2400,  12'd1365, 1'b0, bde_pkg::ERR_NONE},
    // Friday rest: the final skip off 31/12/9999 overflows
    '{3'd6, 5'd31, 4'd12, 14'd9999,  12'd0,    1'b1, bde_pkg::ERR_OVERFLOW},
    // rest 7 matches nothing: every day counts, no skip
    '{3'd7, 5'd1,  4'd1,  14'd2000,  12'd6,    1'b0, bde_pkg::ERR_NONE},
    // Saturday rest, 1/1/2000 is a Saturday
    '{3'd0, 5'd1,  4'd1,  14'd2000,  12'd0,    1'b0, bde_pkg::ERR_NONE}
  };

  business_day_end_date_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- calendar

  function automatic bit leap_year(input int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return y % 400 == 0;
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Zeller, 0 = Saturday; Jan/Feb count as months 13/14 of the year before
  function automatic int unsigned zeller_weekday(input int unsigned d, input int unsigned m,
                                                 input int unsigned y);
    int unsigned mm;
    int unsigned yy;
    mm = m;
    yy = y;
    if (mm < 3) begin
      mm += 12;
      yy -= 1;
    end
    return (d + (13 * (mm + 1)) / 5 + yy % 100 + (yy % 100) / 4 + (yy / 100) / 4
            + 5 * (yy / 100)) % 7;
  endfunction

  // one calendar day forward; 0 when stepping past 31/12/9999
  function automatic bit advance_day(inout int unsigned d, inout int unsigned m,
                                     inout int unsigned y);
    if (d == month_days(m, y)) begin
      d = 1;
      if (m == 12) begin
        m = 1;
        if (y >= 9999) return 1'b0;
        y += 1;
      end else begin
        m += 1;
      end
    end else begin
      d += 1;
    end
    return 1'b1;
  endfunction

  function automatic end_date_t predict_end_date(input logic [4:0] sd, input logic [3:0] sm,
                                                 input logic [13:0] sy,
                                                 input logic [11:0] cnt,
                                                 input logic [2:0] rest);
    end_date_t   r;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned left;
    r = '{5'd0, 4'd0, 14'd0, 3'd0, bde_pkg::ERR_NONE};
    d = sd;
    m = sm;
    y = sy;
    left = cnt;
    if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > month_days(m, y)) begin
      r.err = bde_pkg::ERR_INVALID;
      return r;
    end
    while (left != 0) begin
      if (zeller_weekday(d, m, y) != rest) left -= 1;
      if (!advance_day(d, m, y)) begin
        r.err = bde_pkg::ERR_OVERFLOW;
        return r;
      end
    end
    // landed on the rest day: one more step
    if (zeller_weekday(d, m, y) == rest) begin
      if (!advance_day(d, m, y)) begin
        r.err = bde_pkg::ERR_OVERFLOW;
        return r;
      end
    end
    r.day     = 5'(d);
    r.month   = 4'(m);
    r.year    = 14'(y);
    r.weekday = 3'(zeller_weekday(d, m, y));
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic check_end_date(input logic [31:0] word);
    end_date_t want;
    if (pending_dates.size() == 0) begin
      report_mismatch("unexpected result word", 32'd0, word);
      return;
    end
    want = pending_dates.pop_front();
    if (word[4:0] !== want.day)     report_mismatch("end_day", want.day, word[4:0]);
    if (word[8:5] !== want.month)   report_mismatch("end_month", want.month, word[8:5]);
    if (word[22:9] !== want.year)   report_mismatch("end_year", want.year, word[22:9]);
    if (word[25:23] !== want.weekday)
      report_mismatch("end_weekday", want.weekday, word[25:23]);
    if (word[27:26] !== want.err)   report_mismatch("error_code", want.err, word[27:26]);
  endtask

  // Result side: check each accepted word, then pick out_tready for the next
  // edge. A hold request parks out_tready low until the hold_left countdown runs out.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_end_date(out_tdata);
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_requests != holds_served) begin
        hold_left    <= HOLD_CYCLES;
        holds_served <= holds_served + 1;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // offer one start word, with random idle cycles first; valid stays high
  // after acceptance so back-to-back words need no extra edge
  task automatic send_start_date(input logic [4:0] d, input logic [3:0] m,
                                 input logic [13:0] y, input logic [11:0] n,
                                 input bit typed, input bde_pkg::err_code_t typed_err);
    end_date_t want;
    if (typed) want = '{5'd0, 4'd0, 14'd0, 3'd0, typed_err};
    else       want = predict_end_date(d, m, y, n, rest_setting);
    while (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, n, y, m, d};
    do @(posedge clk); while (!in_tready);
    pending_dates.push_back(want);
  endtask

  // drain all results, then a short pause before touching the register
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write, then read back
  task automatic write_rest_weekday(input logic [2:0] v);
    logic [31:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {bde_pkg::REG_REST_WEEKDAY, 2'b00};
    cfg_pwdata  <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    rest_setting = v;
    if (rd !== 32'(v)) report_mismatch("rest_weekday readback", 32'(v), rd);
  endtask

  function automatic logic [11:0] random_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 12'($urandom_range(63));
    if (r < 95) return 12'($urandom_range(1000));
    return 12'($urandom_range(4095));   // few long walks
  endfunction

  // mostly valid dates with random content; some close to the end of 9999,
  // the rest raw noise (mostly invalid dates)
  task automatic random_start_date(output logic [4:0] d, output logic [3:0] m,
                                   output logic [13:0] y, output logic [11:0] n);
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(99);
    if (kind < 70) begin
      pick = $urandom_range(3);
      if (pick < 2)       y = 14'($urandom_range(9999, 1));
      else if (pick == 2) y = 14'(100 * $urandom_range(99, 1) + $urandom_range(3));
      else                y = 14'($urandom_range(9999, 8192));
      m = 4'($urandom_range(12, 1));
      d = 5'($urandom_range(month_days(m, y), 1));
      n = random_count();
    end else if (kind < 82) begin
      y = 14'd9999;
      m = 4'd12;
      d = 5'($urandom_range(31, 15));
      n = 12'($urandom_range(20));
    end else begin
      d = 5'($urandom);
      m = 4'($urandom);
      y = 14'($urandom);
      n = 12'($urandom);
    end
  endtask

  initial begin
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [11:0] n;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; a row with another rest day drains the block first
    foreach (start_rows[i]) begin
      if (start_rows[i].rest != rest_setting) begin
        settle_block();
        write_rest_weekday(start_rows[i].rest);
      end
      send_start_date(start_rows[i].day, start_rows[i].month, start_rows[i].year,
                      start_rows[i].count, start_rows[i].typed, start_rows[i].err);
    end
    settle_block();

    // random phases, one rest day each: Saturday, Friday, none, two more
    phase_rests[4] = 3'($urandom_range(7));
    foreach (phase_rests[p]) begin
      write_rest_weekday(phase_rests[p]);
      calm = (p == 1);
      if (p == 0) hold_requests++;    // result side stalls while words keep coming
      repeat (ITEMS_PER_PHASE) begin
        random_start_date(d, m, y, n);
        send_start_date(d, m, y, n, 1'b0, bde_pkg::ERR_NONE);
      end
      settle_block();
    end
    calm = 1'b0;

    // nothing more may arrive
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // slowest correct run is well under 7 ms
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
